// ----- src/fir_filter_q16_round_assert.svh -----
// Assertion macros shared by the FIR filter RTL.
// Each macro expects signals clk and rst_n in the enclosing module.
`ifndef FIR_FILTER_Q16_ROUND_ASSERT_SVH
`define FIR_FILTER_Q16_ROUND_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FIR_Q16_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FIR_Q16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fir_q16_pkg.sv -----
// Shared types and fixed constants of the Q16 rounding FIR filter.
// No dependencies; imported by the interfaces, the MAC, the filter top and the testbench.
package fir_q16_pkg;

    localparam int CFG_W    = 6;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 5;
    localparam int PROD_W   = 32;
    localparam int OUT_W    = 16;
    localparam int OUT_SHIFT = 16;

    localparam logic [PROD_W-1:0] ROUND_CONST = 32'h0000_8000;

    // Item action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_ctrl_t;

endpackage

// ----- src/fir_q16_if.sv -----
// Handshake channel interfaces of the FIR filter: item, result, configuration.
// Depends on fir_q16_pkg for field widths.
interface fir_q16_item_if
    import fir_q16_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
    logic                       is_last;

    modport source (output valid, action, sample, tap_index, tap_value, is_last,
                    input ready);
    modport sink (input valid, action, sample, tap_index, tap_value, is_last,
                  output ready);
endinterface

interface fir_q16_result_if
    import fir_q16_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_sample;
    logic                    overflow;
    logic                    last_out;

    modport source (output valid, out_sample, overflow, last_out, input ready);
    modport sink (input valid, out_sample, overflow, last_out, output ready);
endinterface

interface fir_q16_cfg_if
    import fir_q16_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- src/fir_q16_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module fir_q16_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fir_q16_mac.sv -----
// Shared multiply-accumulate unit: registered 16x16 product, wide accumulator.
// Depends on fir_q16_pkg for widths and the control struct.
module fir_q16_mac
    import fir_q16_pkg::*;
#(
    parameter int ACC_W = 37
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [ACC_W-1:0]    acc,
    output logic                       done
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample;
    end

    // Track product validity and the final product of a window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            prod_vld_reg  <= ctrl.valid;
            prod_last_reg <= ctrl.valid && ctrl.last;
            done_reg      <= prod_vld_reg && prod_last_reg;
            // Clear on a new sample, accumulate each valid product
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ----- src/fir_filter_q16_round.sv -----
// Direct-form FIR filter: after a sample transfers, the filter issues K operand reads,
// K = taps in use (1..MAX_TAPS), passes two multiply-accumulate stages, a drain handoff
// and the result put, and takes no new item until the put is done; a result still held by
// the sink stalls the put. A tap load is written at its transfer.
// Reset clears coefficients and delay line at once through per-entry valid bits,
// sets tap_count to 1 and the write pointer to zero; no clearing pass is needed.
`include "fir_filter_q16_round_assert.svh"

module fir_filter_q16_round
    import fir_q16_pkg::*;
#(
    parameter int MAX_TAPS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    fir_q16_item_if.sink      item,
    fir_q16_result_if.source  result,
    fir_q16_cfg_if.sink       cfg
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW    = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int ACC_W = PROD_W + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0);
    localparam logic [NW-1:0] TAPS_N    = NW'(MAX_TAPS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_PUT} state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            tap_reg, tap_next;
    logic [AW-1:0]            slot_reg, slot_next;
    logic [AW-1:0]            wr_ptr_reg, wr_ptr_next;
    logic                     last_reg, last_next;
    logic                     res_valid_reg, res_valid_next;
    logic [CFG_W-1:0]         tap_count_reg;
    logic signed [OUT_W-1:0]  res_sample_reg;
    logic                     res_ovf_reg;
    logic                     res_last_reg;
    logic [MAX_TAPS-1:0]      coef_vld_reg;
    logic [MAX_TAPS-1:0]      delay_vld_reg;
    logic                     op_valid_reg;
    logic                     op_last_reg;
    logic                     coef_ok_reg;
    logic                     delay_ok_reg;

    logic [NW-1:0]            tc_n, k_n, km1_n, newest_n, start_n, idx_n;
    logic [AW-1:0]            km1;
    logic                     idx_ok;
    logic                     item_fire, sample_fire, load_fire;
    logic                     last_issue, res_free, put_fire;
    logic [SAMPLE_W-1:0]      coef_rdata, delay_rdata;
    logic signed [SAMPLE_W-1:0] mac_coef, mac_sample;
    mac_ctrl_t                mac_ctrl;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mac_done;
    logic [PROD_W-1:0]        rounded;
    logic [ACC_W-PROD_W:0]    acc_hi;
    logic                     ovf;

    // Configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CFG_W'(1);
        end
        else if (cfg.valid)
        begin
            tap_count_reg <= cfg.data;
        end
    end

    // Clamp the tap count and find the oldest slot of the window
    always_comb
    begin
        tc_n     = NW'(tap_count_reg);
        k_n      = (tc_n == '0) ? NW'(1) : ((tc_n > TAPS_N) ? TAPS_N : tc_n);
        km1_n    = k_n - NW'(1);
        km1      = km1_n[AW-1:0];
        newest_n = NW'(wr_ptr_reg);
        start_n  = (newest_n >= km1_n) ? (newest_n - km1_n)
                                       : (newest_n + TAPS_N - km1_n);
        idx_n    = NW'(item.tap_index);
        idx_ok   = (idx_n < TAPS_N);
    end

    // Handshake decode
    assign item.ready  = (state_reg == ST_IDLE);
    assign item_fire   = item.valid && item.ready;
    assign sample_fire = item_fire && (item.action == ACT_SAMPLE);
    assign load_fire   = item_fire && (item.action == ACT_LOAD) && idx_ok;
    assign last_issue  = (state_reg == ST_RUN) && (tap_reg == km1);
    assign res_free    = !res_valid_reg || result.ready;
    assign put_fire    = (state_reg == ST_PUT) && res_free;

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        slot_next   = slot_reg;
        wr_ptr_next = wr_ptr_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next  = ST_RUN;
                    tap_next    = '0;
                    slot_next   = start_n[AW-1:0];
                    wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
                    last_next   = item.is_last;
                end
            end
            ST_RUN:
            begin
                tap_next  = tap_reg + AW'(1);
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        wr_ptr_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_valid_next = put_fire || (res_valid_reg && !result.ready);
    end

    // State and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            slot_reg      <= '0;
            wr_ptr_reg    <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            slot_reg      <= slot_next;
            wr_ptr_reg    <= wr_ptr_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Round the wrapped sum and flag an exact sum outside 32 bits
    assign rounded = mac_acc[PROD_W-1:0] + ROUND_CONST;
    assign acc_hi  = mac_acc[ACC_W-1:PROD_W-1];
    assign ovf     = !((&acc_hi) || !(|acc_hi));

    // Result payload
    always_ff @(posedge clk)
    begin
        if (put_fire)
        begin
            res_sample_reg <= rounded[OUT_SHIFT +: OUT_W];
            res_ovf_reg    <= ovf;
            res_last_reg   <= last_reg;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.out_sample = res_sample_reg;
    assign result.overflow   = res_ovf_reg;
    assign result.last_out   = res_last_reg;

    // Entry valid bits: unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg  <= '0;
            delay_vld_reg <= '0;
        end
        else
        begin
            if (load_fire)
            begin
                coef_vld_reg[idx_n[AW-1:0]] <= 1'b1;
            end
            if (put_fire && last_reg)
            begin
                delay_vld_reg <= '0;
            end
            else if (sample_fire)
            begin
                delay_vld_reg[wr_ptr_reg] <= 1'b1;
            end
        end
    end

    // Align valid flags with the registered RAM reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            op_last_reg  <= 1'b0;
            coef_ok_reg  <= 1'b0;
            delay_ok_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= (state_reg == ST_RUN);
            op_last_reg  <= last_issue;
            coef_ok_reg  <= coef_vld_reg[tap_reg];
            delay_ok_reg <= delay_vld_reg[slot_reg];
        end
    end

    fir_q16_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (load_fire),
        .waddr (idx_n[AW-1:0]),
        .wdata (item.tap_value),
        .re    (state_reg == ST_RUN),
        .raddr (tap_reg),
        .rdata (coef_rdata)
    );

    fir_q16_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (sample_fire),
        .waddr (wr_ptr_reg),
        .wdata (item.sample),
        .re    (state_reg == ST_RUN),
        .raddr (slot_reg),
        .rdata (delay_rdata)
    );

    // Zero operands from entries never written since reset or block end
    assign mac_coef   = coef_ok_reg  ? signed'(coef_rdata)  : '0;
    assign mac_sample = delay_ok_reg ? signed'(delay_rdata) : '0;

    assign mac_ctrl.clear = sample_fire;
    assign mac_ctrl.valid = op_valid_reg;
    assign mac_ctrl.last  = op_last_reg;

    fir_q16_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (mac_coef),
        .sample (mac_sample),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    `FIR_Q16_ASSERT_SAME(a_done_in_drain, mac_done, state_reg == ST_DRAIN, "accumulator finished outside drain")
    `FIR_Q16_ASSERT_SAME(a_tap_in_window, state_reg == ST_RUN, tap_reg <= km1, "tap index ran past the window")
    `FIR_Q16_ASSERT_SAME(a_last_is_valid, op_last_reg, op_valid_reg, "final operand flagged without valid")
    `FIR_Q16_ASSERT_NEXT(a_block_end_clear, put_fire && last_reg, (delay_vld_reg == '0) && (wr_ptr_reg == '0), "delay line not cleared after block end")

endmodule

// ----- sim/fir_filter_q16_round_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Q16 rounding FIR filter: taps, samples, tap-count settings.
// Depends on fir_q16_pkg, the channel interfaces in fir_q16_if and the top fir_filter_q16_round.
module fir_filter_q16_round_tb
    import fir_q16_pkg::*;
();

    localparam int     MAX_TAPS      = 32;
    localparam int     SETTLE_CYCLES = MAX_TAPS + 10;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     MAX_WAIT      = 12;
    localparam int     PRINT_CAP     = 40;
    localparam longint ACC_MAX       = 64'sd2147483647;
    localparam longint ACC_MIN       = -64'sd2147483648;

    typedef struct {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           tap_index;
        logic signed [SAMPLE_W-1:0] tap_value;
        logic                       is_last;
    } fir_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] out_sample;
        logic                    overflow;
        logic                    last_out;
    } fir_result_t;

    // Mirror of the filter state; predicts each output and checks it on arrival
    class fir_response_tracker;
        logic signed [SAMPLE_W-1:0] history[MAX_TAPS];
        logic signed [SAMPLE_W-1:0] coeffs[MAX_TAPS];
        int                         wr_ptr;
        logic [CFG_W-1:0]           tap_count;
        fir_result_t                pending_outputs[$];
        int                         mismatches;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (coeffs[i]) coeffs[i] = '0;
            wr_ptr     = 0;
            tap_count  = CFG_W'(1);
            mismatches = 0;
        endfunction

        function void set_tap_count(logic [CFG_W-1:0] value);
            tap_count = value;
        endfunction

        function int pending_count();
            return pending_outputs.size();
        endfunction

        function int taps_in_use();
            if (tap_count == 0)
                return 1;
            if (int'(tap_count) > MAX_TAPS)
                return MAX_TAPS;
            return int'(tap_count);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Apply one accepted item; a sample pushes its predicted output
        function void note_item(fir_item_t it);
            fir_result_t      r;
            int               k;
            int               newest;
            int               slot;
            longint           exact;
            logic [PROD_W-1:0] rounded;
            if (it.action == ACT_LOAD) begin
                if (int'(it.tap_index) < MAX_TAPS)
                    coeffs[it.tap_index] = it.tap_value;
                return;
            end
            newest          = wr_ptr;
            history[newest] = it.sample;
            wr_ptr          = (newest + 1) % MAX_TAPS;
            k               = taps_in_use();
            exact           = 0;
            // Oldest sample in the window meets the first tap
            for (int m = 0; m < k; m++) begin
                slot  = (newest + MAX_TAPS - (k - 1 - m)) % MAX_TAPS;
                exact += longint'(coeffs[m]) * longint'(history[slot]);
            end
            rounded      = exact[PROD_W-1:0] + ROUND_CONST;
            r.out_sample = rounded[PROD_W-1:OUT_SHIFT];
            r.overflow   = (exact > ACC_MAX) || (exact < ACC_MIN);
            r.last_out   = it.is_last;
            pending_outputs.push_back(r);
            // Clear the window after the last sample of a block
            if (it.is_last) begin
                foreach (history[i]) history[i] = '0;
                wr_ptr = 0;
            end
        endfunction

        task check_result(fir_result_t got);
            fir_result_t want;
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output out=%0d ovf=%0b last=%0b",
                                          got.out_sample, got.overflow, got.last_out));
                return;
            end
            want = pending_outputs.pop_front();
            if (got.out_sample !== want.out_sample || got.overflow !== want.overflow ||
                got.last_out !== want.last_out)
                report_mismatch($sformatf("out=%0d/%0d ovf=%0b/%0b last=%0b/%0b (got/want)",
                                          got.out_sample, want.out_sample,
                                          got.overflow, want.overflow,
                                          got.last_out, want.last_out));
        endtask

        task check_leftovers();
            if (pending_outputs.size() != 0)
                report_mismatch($sformatf("%0d outputs never arrived", pending_outputs.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   item_burst;
    bit   res_burst;
    int   cycles;

    fir_response_tracker board;

    fir_q16_item_if   item_ch();
    fir_q16_result_if res_ch();
    fir_q16_cfg_if    cfg_ch();

    fir_filter_q16_round #(
        .MAX_TAPS(MAX_TAPS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Full-scale values often, otherwise any 16-bit word
    function automatic logic signed [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic fir_item_t load_item(int idx, logic signed [SAMPLE_W-1:0] value,
                                            logic last);
        fir_item_t it;
        it.action    = ACT_LOAD;
        it.sample    = SAMPLE_W'($urandom);
        it.tap_index = IDX_W'(idx);
        it.tap_value = value;
        it.is_last   = last;
        return it;
    endfunction

    function automatic fir_item_t sample_item(logic signed [SAMPLE_W-1:0] value, logic last);
        fir_item_t it;
        it.action    = ACT_SAMPLE;
        it.sample    = value;
        it.tap_index = IDX_W'($urandom);
        it.tap_value = SAMPLE_W'($urandom);
        it.is_last   = last;
        return it;
    endfunction

    // Present one item after a random gap; return at the edge of its transfer
    task automatic send_item(fir_item_t it);
        int gap;
        gap = draw_wait(item_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= it.action;
        item_ch.sample    <= it.sample;
        item_ch.tap_index <= it.tap_index;
        item_ch.tap_value <= it.tap_value;
        item_ch.is_last   <= it.is_last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        board.note_item(it);
    endtask

    // Drop valid and hold off until every predicted output has arrived
    task automatic hold_until_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (board.pending_count() != 0) @(negedge clk);
    endtask

    // Drain, let a trailing tap load finish, then write the tap count
    task automatic write_tap_count(logic [CFG_W-1:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        board.set_tap_count(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Accept outputs after a random stall each, check at the transfer edge
    initial
    begin
        fir_result_t got;
        int          stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.out_sample = res_ch.out_sample;
                got.overflow   = res_ch.overflow;
                got.last_out   = res_ch.last_out;
                board.check_result(got);
                stall = draw_wait(res_burst);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
        $display("** fir_filter_q16_round: FAILED **");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] settings[10];
        int               k;
        int               count;
        board = new();

        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.action    = ACT_SAMPLE;
        item_ch.sample    = '0;
        item_ch.tap_index = '0;
        item_ch.tap_value = '0;
        item_ch.is_last   = 1'b0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        item_burst        = 1'b0;
        res_burst         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // One tap from reset: zero taps, full-scale products, rounding wrap
        send_item(sample_item(16'sh7FFF, 1'b0));
        send_item(load_item(0, 16'sh8000, 1'b1));
        send_item(sample_item(16'sh8000, 1'b0));
        send_item(sample_item(16'sh7FFF, 1'b0));
        send_item(load_item(0, 16'sh0001, 1'b0));
        send_item(sample_item(16'sh8000, 1'b0));
        send_item(load_item(31, 16'sh8000, 1'b0));
        send_item(load_item(0, 16'sh7FFF, 1'b0));
        hold_until_drained();
        send_item(sample_item(16'sh8000, 1'b1));

        // Four taps at full scale: partial window, overflow, wrap to zero
        write_tap_count(CFG_W'(4));
        for (int i = 0; i < 4; i++)
            send_item(load_item(i, 16'sh8000, 1'b0));
        for (int i = 0; i < 4; i++)
            send_item(sample_item(16'sh8000, i == 3));
        send_item(sample_item(16'sh0001, 1'b0));
        send_item(sample_item(16'sh7FFF, 1'b1));

        // Random phases over several tap counts, extremes included
        settings = '{6'd1, 6'd0, 6'd3, 6'd32, 6'd63, 6'd2, 6'd33, 6'd0, 6'd17, 6'd4};
        settings[7] = CFG_W'($urandom_range(0, 63));
        for (int p = 0; p < 10; p++)
        begin
            write_tap_count(settings[p]);
            item_burst = (p % 3 == 1);
            res_burst  = (p % 4 == 2);
            k = board.taps_in_use();
            count = (k > 16) ? 24 : 45;
            // Fill the taps in use, then stream mostly samples
            for (int i = 0; i < k; i++)
                send_item(load_item(i, pick_word(), 1'($urandom_range(0, 1))));
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
                if ($urandom_range(0, 99) < 15)
                    send_item(load_item($urandom_range(0, MAX_TAPS - 1), pick_word(),
                                        1'($urandom_range(0, 1))));
                else
                    send_item(sample_item(pick_word(), $urandom_range(0, 11) == 0));
            end
        end

        // Drain and let the block settle before the verdict
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        board.check_leftovers();
        if (board.mismatches == 0)
            $display("** fir_filter_q16_round: PASSED **");
        else
            $display("** fir_filter_q16_round: FAILED **");
        $finish;
    end

endmodule
